// ===== sv/bmg_pkg.sv =====
`timescale 1ns / 1ps
// shared types, widths, latencies and series tables for the box-muller gaussian generator
package bmg_pkg;

  localparam int UNIFORM_BITS = 24;
  localparam int SAMPLE_W     = 32;
  localparam int STD_W        = 24;
  localparam int THRESH_W     = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int ROOT_W       = 31;
  localparam int TRIG_W       = 31;
  localparam int SERIES_TERMS = 6;

  localparam logic [STD_W-1:0] STD_RESET = 24'd65536;

  // register stages of each datapath section
  localparam int MAG_LAT   = 64;
  localparam int TRIG_LAT  = 21;
  localparam int SCALE_LAT = 3;
  localparam int TOTAL_LAT = MAG_LAT + SCALE_LAT;
  localparam int ANG_DELAY = MAG_LAT - TRIG_LAT;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN   = 2'd0,
    CFG_STD    = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [UNIFORM_BITS-1:0] uniform_a;
    logic [UNIFORM_BITS-1:0] uniform_b;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] gauss_sample;
    logic                       saturated;
  } out_item_t;

  // taylor divisor for term k+1: (2k+1)(2k+2) for cosine, (2k+2)(2k+3) for sine
  function automatic logic [7:0] series_div(input logic [2:0] k, input logic use_sin);
    logic [7:0] d;
    d = 8'd2;
    case (k)
      3'd0: d = use_sin ? 8'd6   : 8'd2;
      3'd1: d = use_sin ? 8'd20  : 8'd12;
      3'd2: d = use_sin ? 8'd42  : 8'd30;
      3'd3: d = use_sin ? 8'd72  : 8'd56;
      3'd4: d = use_sin ? 8'd110 : 8'd90;
      3'd5: d = use_sin ? 8'd156 : 8'd132;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), quotient estimate is low by at most one
  function automatic logic [31:0] series_recip(input logic [2:0] k, input logic use_sin);
    logic [31:0] r;
    r = 32'd2147483648;
    case (k)
      3'd0: r = use_sin ? 32'd715827882 : 32'd2147483648;
      3'd1: r = use_sin ? 32'd214748364 : 32'd357913941;
      3'd2: r = use_sin ? 32'd102261126 : 32'd143165576;
      3'd3: r = use_sin ? 32'd59652323  : 32'd76695844;
      3'd4: r = use_sin ? 32'd39045157  : 32'd47721858;
      3'd5: r = use_sin ? 32'd27531841  : 32'd32537631;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/bmg_log_sqrt.sv =====
`timescale 1ns / 1ps
// magnitude pipeline: sqrt(-2 ln u1) via squaring log2, constant multiply and bitwise root
module bmg_log_sqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [bmg_pkg::UNIFORM_BITS-1:0] uniform_a,
  output logic [bmg_pkg::ROOT_W-1:0]       root
);
  import bmg_pkg::*;

  localparam int LOG_STEPS  = 30;
  localparam int EXP_W      = 6;
  localparam int NL_W       = 36;
  localparam int HALF_W     = 18;
  localparam int K_W        = 29;
  localparam int P_W        = HALF_W + K_W;
  localparam int L_W        = 36;
  localparam int V_W        = 62;
  localparam int SQRT_STEPS = 31;
  localparam logic [K_W-1:0] TWO_LN2_Q28 = 29'd372130559;

  logic [4:0]       msb;
  logic [31:0]      norm_nxt, norm_r;
  logic [EXP_W-1:0] exp_nxt;
  logic [EXP_W-1:0] exp_r [0:LOG_STEPS];

  logic [31:0] y_in     [0:LOG_STEPS-1];
  logic [29:0] f_in     [0:LOG_STEPS-1];
  logic [63:0] sq       [0:LOG_STEPS-1];
  logic [31:0] y_nxt    [0:LOG_STEPS-2];
  logic [31:0] y_r      [0:LOG_STEPS-2];
  logic [29:0] frac_nxt [0:LOG_STEPS-1];
  logic [29:0] frac_r   [0:LOG_STEPS-1];

  logic [NL_W-1:0] nl;
  logic [P_W-1:0]  plo_nxt, plo_r, phi_nxt, phi_r;
  logic [63:0]     lsum;
  logic [L_W-1:0]  l_nxt, l_r;

  logic [V_W-1:0] v_in  [0:SQRT_STEPS-1];
  logic [V_W-1:0] r_in  [0:SQRT_STEPS-1];
  logic [V_W-1:0] bitv  [0:SQRT_STEPS-1];
  logic [V_W-1:0] trial [0:SQRT_STEPS-1];
  logic           take  [0:SQRT_STEPS-1];
  logic [V_W-1:0] r_nxt [0:SQRT_STEPS-1];
  logic [V_W-1:0] res_r [0:SQRT_STEPS-1];
  logic [V_W-1:0] v_nxt [0:SQRT_STEPS-2];
  logic [V_W-1:0] v_r   [0:SQRT_STEPS-2];

  // normalize u1 so its leading one sits at bit 31
  always_comb begin
    msb = '0;
    for (int i = 0; i < UNIFORM_BITS; i++) begin
      if (uniform_a[i]) begin
        msb = 5'(i);
      end
    end
    norm_nxt = 32'(uniform_a) << (5'd31 - msb);
    exp_nxt  = EXP_W'(UNIFORM_BITS) - EXP_W'(msb);
  end

  // one fraction bit of log2 per stage
  always_comb begin
    y_in[0] = norm_r;
    f_in[0] = '0;
    for (int i = 1; i < LOG_STEPS; i++) begin
      y_in[i] = y_r[i-1];
      f_in[i] = frac_r[i-1];
    end
    for (int i = 0; i < LOG_STEPS; i++) begin
      sq[i]       = 64'(y_in[i]) * 64'(y_in[i]);
      frac_nxt[i] = f_in[i] | (30'(sq[i][63]) << (LOG_STEPS - 1 - i));
    end
    for (int i = 0; i < LOG_STEPS - 1; i++) begin
      y_nxt[i] = sq[i][63] ? sq[i][63:32] : sq[i][62:31];
    end
  end

  // -2 ln u1 = -log2 u1 * 2 ln 2, split into two partial products
  always_comb begin
    nl      = {exp_r[LOG_STEPS], 30'b0} - NL_W'(frac_r[LOG_STEPS-1]);
    plo_nxt = P_W'(nl[HALF_W-1:0]) * P_W'(TWO_LN2_Q28);
    phi_nxt = P_W'(nl[NL_W-1:HALF_W]) * P_W'(TWO_LN2_Q28);
    lsum    = 64'({phi_r, {HALF_W{1'b0}}}) + 64'(plo_r) + (64'(1) << 27);
    l_nxt   = lsum[63:28];
  end

  // restoring square root, one result bit per stage
  always_comb begin
    v_in[0] = {l_r, 26'b0};
    r_in[0] = '0;
    for (int j = 1; j < SQRT_STEPS; j++) begin
      v_in[j] = v_r[j-1];
      r_in[j] = res_r[j-1];
    end
    for (int j = 0; j < SQRT_STEPS; j++) begin
      bitv[j]  = V_W'(1) << (2 * (SQRT_STEPS - 1 - j));
      trial[j] = r_in[j] + bitv[j];
      take[j]  = v_in[j] >= trial[j];
      r_nxt[j] = take[j] ? (r_in[j] >> 1) + bitv[j] : r_in[j] >> 1;
    end
    for (int j = 0; j < SQRT_STEPS - 1; j++) begin
      v_nxt[j] = take[j] ? v_in[j] - trial[j] : v_in[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_r   <= norm_nxt;
      exp_r[0] <= exp_nxt;
      for (int i = 1; i <= LOG_STEPS; i++) begin
        exp_r[i] <= exp_r[i-1];
      end
      for (int i = 0; i < LOG_STEPS; i++) begin
        frac_r[i] <= frac_nxt[i];
      end
      for (int i = 0; i < LOG_STEPS - 1; i++) begin
        y_r[i] <= y_nxt[i];
      end
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
      l_r   <= l_nxt;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        res_r[j] <= r_nxt[j];
      end
      for (int j = 0; j < SQRT_STEPS - 1; j++) begin
        v_r[j] <= v_nxt[j];
      end
    end
  end

  assign root = res_r[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== sv/bmg_trig.sv =====
`timescale 1ns / 1ps
// angle pipeline: octant reduction and taylor series for cos(2 pi u2)
module bmg_trig (
  input  logic                             clk,
  input  logic                             en,
  input  logic [bmg_pkg::UNIFORM_BITS-1:0] uniform_b,
  output logic [bmg_pkg::TRIG_W-1:0]       cos_val,
  output logic                             cos_neg
);
  import bmg_pkg::*;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef struct packed {
    logic [TRIG_W-1:0] x2;
    logic [TRIG_W-1:0] sum;
    logic              use_sin;
    logic              neg;
  } side_t;

  logic [31:0] ph;
  logic [1:0]  quad;
  logic [29:0] rr, tt;
  logic        swapped;
  logic [61:0] tp_nxt, tp_r;
  logic        sin0_r, neg0_r, sin1_r, neg1_r;
  logic [29:0] xv, x_r;
  logic [59:0] xx_nxt, xx_r;
  logic [60:0] x2_sum;
  logic [TRIG_W-1:0] term0_nxt, term0_r;
  side_t       sd0_nxt, sd0_r;

  logic [TRIG_W-1:0] t_in   [0:SERIES_TERMS-1];
  side_t             sd_in  [0:SERIES_TERMS-1];
  logic [61:0]       pa_nxt [0:SERIES_TERMS-1];
  logic [61:0]       pa_r   [0:SERIES_TERMS-1];
  side_t             sda_r  [0:SERIES_TERMS-1];
  logic [TRIG_W-1:0] n_nxt  [0:SERIES_TERMS-1];
  logic [TRIG_W-1:0] n_r    [0:SERIES_TERMS-1];
  logic [62:0]       nr_nxt [0:SERIES_TERMS-1];
  logic [62:0]       nr_r   [0:SERIES_TERMS-1];
  side_t             sdb_r  [0:SERIES_TERMS-1];
  logic [TRIG_W-1:0] q0     [0:SERIES_TERMS-1];
  logic [7:0]        dv     [0:SERIES_TERMS-1];
  logic [38:0]       rem    [0:SERIES_TERMS-1];
  logic [TRIG_W-1:0] q_div  [0:SERIES_TERMS-1];
  side_t             sdc_nxt [0:SERIES_TERMS-1];
  side_t             sdc_r  [0:SERIES_TERMS-1];
  logic [TRIG_W-1:0] term_r [0:SERIES_TERMS-2];

  // fold the turn into one octant, pick sine or cosine and the sign
  always_comb begin
    ph      = 32'(uniform_b) << (32 - UNIFORM_BITS);
    quad    = ph[31:30];
    rr      = ph[29:0];
    swapped = rr > 30'h2000_0000;
    tt      = swapped ? 30'(31'h4000_0000 - 31'(rr)) : rr;
    tp_nxt  = 62'(tt) * 62'(PI_Q30);
  end

  always_comb begin
    xv        = tp_r[60:31];
    xx_nxt    = 60'(xv) * 60'(xv);
    x2_sum    = 61'(xx_r) + (61'(1) << 29);
    term0_nxt = sin1_r ? 31'(x_r) : ONE_Q30;
    sd0_nxt   = '{x2: x2_sum[60:30], sum: term0_nxt, use_sin: sin1_r, neg: neg1_r};
  end

  // each term: multiply by x^2, multiply by reciprocal, correct the quotient
  always_comb begin
    t_in[0]  = term0_r;
    sd_in[0] = sd0_r;
    for (int k = 1; k < SERIES_TERMS; k++) begin
      t_in[k]  = term_r[k-1];
      sd_in[k] = sdc_r[k-1];
    end
    for (int k = 0; k < SERIES_TERMS; k++) begin
      pa_nxt[k] = 62'(t_in[k]) * 62'(sd_in[k].x2);
      n_nxt[k]  = pa_r[k][60:30];
      nr_nxt[k] = 63'(n_nxt[k]) * 63'(series_recip(3'(k), sda_r[k].use_sin));
      q0[k]     = nr_r[k][62:32];
      dv[k]     = series_div(3'(k), sdb_r[k].use_sin);
      rem[k]    = 39'(n_r[k]) - 39'(q0[k]) * 39'(dv[k]);
      q_div[k]  = q0[k] + TRIG_W'(rem[k] >= 39'(dv[k]));
      sdc_nxt[k] = sdb_r[k];
      // the first, third and fifth terms of the series subtract, the others add
      if ((k % 2) == 0) begin
        sdc_nxt[k].sum = sdb_r[k].sum - q_div[k];
      end else begin
        sdc_nxt[k].sum = sdb_r[k].sum + q_div[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tp_r    <= tp_nxt;
      sin0_r  <= quad[0] ^ swapped;
      neg0_r  <= quad[0] ^ quad[1];
      x_r     <= xv;
      xx_r    <= xx_nxt;
      sin1_r  <= sin0_r;
      neg1_r  <= neg0_r;
      term0_r <= term0_nxt;
      sd0_r   <= sd0_nxt;
      for (int k = 0; k < SERIES_TERMS; k++) begin
        pa_r[k]  <= pa_nxt[k];
        sda_r[k] <= sd_in[k];
        n_r[k]   <= n_nxt[k];
        nr_r[k]  <= nr_nxt[k];
        sdb_r[k] <= sda_r[k];
        sdc_r[k] <= sdc_nxt[k];
      end
      for (int k = 0; k < SERIES_TERMS - 1; k++) begin
        term_r[k] <= q_div[k];
      end
    end
  end

  assign cos_val = sdc_r[SERIES_TERMS-1].sum;
  assign cos_neg = sdc_r[SERIES_TERMS-1].neg;

endmodule

// ===== sv/bmg_scale.sv =====
`timescale 1ns / 1ps
// output pipeline: root times cosine, deviation scaling, mean offset and saturation
module bmg_scale (
  input  logic                                clk,
  input  logic                                en,
  input  logic [bmg_pkg::ROOT_W-1:0]          root,
  input  logic [bmg_pkg::TRIG_W-1:0]          cos_val,
  input  logic                                cos_neg,
  input  logic signed [bmg_pkg::SAMPLE_W-1:0] mean_offset,
  input  logic [bmg_pkg::STD_W-1:0]           std_scale,
  output logic signed [bmg_pkg::SAMPLE_W-1:0] gauss_sample,
  output logic                                saturated
);
  import bmg_pkg::*;

  localparam int P_W   = ROOT_W + TRIG_W;
  localparam int Z_W   = 20;
  localparam int Q_W   = Z_W + STD_W;
  localparam int M_W   = Q_W + 1 - 16;
  localparam int VAL_W = SAMPLE_W + 2;
  localparam logic signed [VAL_W-1:0] MAX_VAL = VAL_W'((64'(1) << (SAMPLE_W - 1)) - 64'(1));
  localparam logic signed [VAL_W-1:0] MIN_VAL = -(VAL_W'(64'(1) << (SAMPLE_W - 1)));

  logic [P_W-1:0]          p_nxt, p_r;
  logic                    neg1_r, neg2_r;
  logic [P_W:0]            z_sum;
  logic [Z_W-1:0]          zmag;
  logic [Q_W-1:0]          q_nxt, q_r;
  logic [Q_W:0]            s_sum;
  logic [M_W-1:0]          smag;
  logic signed [VAL_W-1:0] val;
  logic signed [SAMPLE_W-1:0] gauss_nxt, gauss_r;
  logic                    sat_nxt, sat_r;

  always_comb begin
    p_nxt = P_W'(root) * P_W'(cos_val);
    z_sum = (P_W+1)'(p_r) + ((P_W+1)'(1) << 41);
    zmag  = z_sum[Z_W+41:42];
    q_nxt = Q_W'(zmag) * Q_W'(std_scale);
    s_sum = (Q_W+1)'(q_r) + ((Q_W+1)'(1) << 15);
    smag  = s_sum[Q_W:16];
    // sign goes on the rounded magnitude
    val   = neg2_r ? -$signed(VAL_W'(smag)) : $signed(VAL_W'(smag));
    val   = val + VAL_W'(mean_offset);
    if (val > MAX_VAL) begin
      gauss_nxt = MAX_VAL[SAMPLE_W-1:0];
      sat_nxt   = 1'b1;
    end else if (val < MIN_VAL) begin
      gauss_nxt = MIN_VAL[SAMPLE_W-1:0];
      sat_nxt   = 1'b1;
    end else begin
      gauss_nxt = val[SAMPLE_W-1:0];
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= p_nxt;
      neg1_r  <= cos_neg;
      q_r     <= q_nxt;
      neg2_r  <= neg1_r;
      gauss_r <= gauss_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign gauss_sample = gauss_r;
  assign saturated    = sat_r;

endmodule

// ===== sv/box_muller_gaussian.sv =====
`timescale 1ns / 1ps
// top level of the box-muller gaussian sample generator
//
// Takes one pair of uniform fractions per clock unless stalled and returns
// sqrt(-2 ln u1) * cos(2 pi u2) scaled by std_scale and offset by mean_offset, signed Q16.16,
// saturated to 32 bits. Pairs whose u1 is at or below the threshold register give no result;
// the next pair is the redraw. Every accepted pair moves through a 67-stage pipeline (64 stages
// for the squaring logarithm and bitwise square root, the angle series running in parallel,
// then 3 stages of scaling), and results stream out one per clock while out_stall does not
// hold the pipeline. out_stall freezes the whole pipeline only while the output stage holds a
// result; while that stage is empty every stage moves on. The threshold takes effect for
// pairs offered after the write; mean and deviation are read in the scaling stages, so they
// also reach pairs in flight. Registers should be written while idle.
module box_muller_gaussian (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bmg_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bmg_pkg::out_item_t               out_data,
  input  logic                             cfg_wr_en,
  input  logic [bmg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import bmg_pkg::*;

  logic signed [SAMPLE_W-1:0] mean_r;
  logic [STD_W-1:0]           std_r;
  logic [THRESH_W-1:0]        thr_r;

  logic                    en;
  logic                    keep;
  logic [TOTAL_LAT-1:0]    vld_r;
  logic [UNIFORM_BITS-1:0] ub_r [0:ANG_DELAY-1];
  logic [ROOT_W-1:0]       root;
  logic [TRIG_W-1:0]       cos_val;
  logic                    cos_neg;
  logic signed [SAMPLE_W-1:0] gauss;
  logic                    sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      std_r  <= STD_RESET;
      thr_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MEAN:   mean_r <= cfg_wdata[SAMPLE_W-1:0];
        CFG_STD:    std_r  <= cfg_wdata[STD_W-1:0];
        CFG_THRESH: thr_r  <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline holds only when the output stage has a result that is not taken
  assign en       = !(vld_r[TOTAL_LAT-1] && out_stall);
  assign in_stall = !en;

  // both fractions compared at a common scale
  assign keep = in_valid && en &&
                ({in_data.uniform_a, {THRESH_W{1'b0}}} > {thr_r, {UNIFORM_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL_LAT-2:0], keep};
    end
  end

  // u2 waits so the angle lands together with the root
  always_ff @(posedge clk) begin
    if (en) begin
      ub_r[0] <= in_data.uniform_b;
      for (int i = 1; i < ANG_DELAY; i++) begin
        ub_r[i] <= ub_r[i-1];
      end
    end
  end

  bmg_log_sqrt u_mag (
    .clk       (clk),
    .en        (en),
    .uniform_a (in_data.uniform_a),
    .root      (root)
  );

  bmg_trig u_trig (
    .clk       (clk),
    .en        (en),
    .uniform_b (ub_r[ANG_DELAY-1]),
    .cos_val   (cos_val),
    .cos_neg   (cos_neg)
  );

  bmg_scale u_scale (
    .clk          (clk),
    .en           (en),
    .root         (root),
    .cos_val      (cos_val),
    .cos_neg      (cos_neg),
    .mean_offset  (mean_r),
    .std_scale    (std_r),
    .gauss_sample (gauss),
    .saturated    (sat)
  );

  assign out_valid             = vld_r[TOTAL_LAT-1];
  assign out_data.gauss_sample = gauss;
  assign out_data.saturated    = sat;

endmodule
